// ===== rtl/core/mss_pkg.sv =====
// shared types and constants for the mips subset stepper
package mss_pkg;

    localparam int MemBytesDefault = 4096;

    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0a;
    localparam logic [5:0] OP_SLTIU   = 6'h0b;
    localparam logic [5:0] OP_ANDI    = 6'h0c;
    localparam logic [5:0] OP_ORI     = 6'h0d;
    localparam logic [5:0] OP_LUI     = 6'h0f;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_LBU     = 6'h24;
    localparam logic [5:0] OP_LHU     = 6'h25;
    localparam logic [5:0] OP_SB      = 6'h28;
    localparam logic [5:0] OP_SH      = 6'h29;
    localparam logic [5:0] OP_SW      = 6'h2b;
    localparam logic [5:0] OP_LL      = 6'h30;
    localparam logic [5:0] OP_SC      = 6'h38;

    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SRL  = 6'h02;
    localparam logic [5:0] FN_JR   = 6'h08;
    localparam logic [5:0] FN_ADD  = 6'h20;
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUB  = 6'h22;
    localparam logic [5:0] FN_SUBU = 6'h23;
    localparam logic [5:0] FN_AND  = 6'h24;
    localparam logic [5:0] FN_OR   = 6'h25;
    localparam logic [5:0] FN_NOR  = 6'h27;
    localparam logic [5:0] FN_SLT  = 6'h2a;
    localparam logic [5:0] FN_SLTU = 6'h2b;

    localparam logic [2:0] ST_EXEC   = 3'd0;
    localparam logic [2:0] ST_WRAP   = 3'd1;
    localparam logic [2:0] ST_RANGE  = 3'd2;
    localparam logic [2:0] ST_UNKNOWN = 3'd3;
    localparam logic [2:0] ST_LOADED = 3'd4;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    localparam logic [0:0] REG_PROGRAM_WORDS = 1'b0;

    typedef struct packed {
        logic        command;
        logic [11:0] load_address;
        logic [7:0]  load_byte;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] next_pc;
        logic        reg_written;
        logic [4:0]  reg_index;
        logic [31:0] reg_value;
        logic [2:0]  store_bytes;
        logic [11:0] store_address;
    } t_rsp;

    // memory port selection driven by the controller
    typedef enum logic [1:0] {
        MA_LOAD, MA_FETCH, MA_DATA
    } t_maddr;

    // controller to datapath commands
    typedef struct packed {
        logic       take_req;
        logic       clr_clear;
        logic       clr_step;
        logic       mem_rd;
        logic       mem_wr;
        t_maddr     msel;
        logic [1:0] bidx;
        logic       cap_ins;
        logic       cap_data;
        logic       reg_rd;
        logic       exec;
        logic       commit;
        logic       fin_range;
        logic       fin_load;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic       is_load;
        logic       in_range;
        logic [2:0] ld_bytes;
        logic [2:0] st_bytes;
        logic       clr_done;
    } t_sts;

endpackage

// ===== rtl/core/mss_ram.sv =====
// generic single-port ram with registered read
module mss_ram #(
    parameter int Width = 8,
    parameter int Depth = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // write or read one entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/mss_ctrl.sv =====
// sequencing state machine of the stepper
module mss_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_ready,
    input  mss_pkg::t_sts i_sts,
    output mss_pkg::t_cmd o_cmd
);
    import mss_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DECIDE, S_FETCH, S_FWAIT, S_REGRD, S_EXEC,
        S_DRD, S_DWAIT, S_DWR, S_COMMIT, S_OUT
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_cnt, n_cnt;
    logic       r_ovalid, n_ovalid;

    assign o_ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid = r_ovalid;

    // next state and commands
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_ovalid = r_ovalid;
        o_cmd    = '0;
        o_cmd.msel = MA_FETCH;
        o_cmd.bidx = r_cnt[1:0];
        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                o_cmd.mem_wr   = 1'b1;
                o_cmd.clr_clear = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    o_cmd.take_req = 1'b1;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_cnt = 3'd0;
                if (i_sts.is_load) begin
                    o_cmd.mem_wr   = 1'b1;
                    o_cmd.msel     = MA_LOAD;
                    o_cmd.fin_load = 1'b1;
                    n_state = S_OUT;
                end else if (!i_sts.in_range) begin
                    o_cmd.fin_range = 1'b1;
                    n_state = S_OUT;
                end else begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                o_cmd.mem_rd = 1'b1;
                n_state = S_FWAIT;
            end
            S_FWAIT: begin
                o_cmd.bidx    = r_cnt[1:0];
                o_cmd.cap_ins = 1'b1;
                if (r_cnt == 3'd3) begin
                    n_state = S_REGRD;
                end else begin
                    n_cnt   = r_cnt + 3'd1;
                    n_state = S_FETCH;
                end
            end
            S_REGRD: begin
                o_cmd.reg_rd = 1'b1;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_cnt = 3'd0;
                if (i_sts.ld_bytes != 3'd0) begin
                    n_state = S_DRD;
                end else if (i_sts.st_bytes != 3'd0) begin
                    n_state = S_DWR;
                end else begin
                    n_state = S_COMMIT;
                end
            end
            S_DRD: begin
                o_cmd.msel   = MA_DATA;
                o_cmd.mem_rd = 1'b1;
                n_state = S_DWAIT;
            end
            S_DWAIT: begin
                o_cmd.cap_data = 1'b1;
                n_cnt = r_cnt + 3'd1;
                n_state = (n_cnt == i_sts.ld_bytes) ? S_COMMIT : S_DRD;
            end
            S_DWR: begin
                o_cmd.msel   = MA_DATA;
                o_cmd.mem_wr = 1'b1;
                n_cnt = r_cnt + 3'd1;
                if (n_cnt == i_sts.st_bytes) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                n_ovalid = 1'b1;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_cnt    <= 3'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end
endmodule

// ===== rtl/core/mss_dpath.sv =====
// registers, memory and execute logic of the stepper
module mss_dpath #(
    parameter int MemBytes = mss_pkg::MemBytesDefault
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  mss_pkg::t_req i_req,
    input  logic [10:0]   i_words,
    input  mss_pkg::t_cmd i_cmd,
    output mss_pkg::t_sts o_sts,
    output mss_pkg::t_rsp o_rsp
);
    import mss_pkg::*;

    localparam int AW = $clog2(MemBytes);

    t_req        r_req;
    logic [31:0] r_pc;
    logic [31:0] r_ins;
    logic [31:0] r_a, r_b;
    logic [31:0] r_ea, r_npc, r_val, r_ldv;
    logic [4:0]  r_dst;
    logic        r_wr;
    logic [2:0]  r_lb, r_sb, r_status;
    logic [AW-1:0] r_clr;
    logic        r_clr_done;
    t_rsp        r_rsp;
    logic [31:0] r_gpr [32];

    // memory port
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata, mem_rdata;
    logic [31:0]   fetch_a, data_a;

    assign fetch_a = r_pc + {30'd0, i_cmd.bidx};
    assign data_a  = r_ea + {30'd0, i_cmd.bidx};

    always_comb begin
        mem_addr  = fetch_a[AW-1:0];
        mem_wdata = r_b[7:0];
        if (i_cmd.clr_clear) begin
            mem_addr  = r_clr;
            mem_wdata = 8'd0;
        end else begin
            case (i_cmd.msel)
                MA_LOAD: begin
                    mem_addr  = AW'(r_req.load_address);
                    mem_wdata = r_req.load_byte;
                end
                MA_DATA: begin
                    mem_addr  = data_a[AW-1:0];
                    case (i_cmd.bidx)
                        2'd0: mem_wdata = r_b[7:0];
                        2'd1: mem_wdata = r_b[15:8];
                        2'd2: mem_wdata = r_b[23:16];
                        default: mem_wdata = r_b[31:24];
                    endcase
                end
                default: mem_addr = fetch_a[AW-1:0];
            endcase
        end
    end

    mss_ram #(.Width(8), .Depth(MemBytes)) u_mem (
        .i_clk  (i_clk),
        .i_we   (i_cmd.mem_wr),
        .i_addr (mem_addr),
        .i_wdata(mem_wdata),
        .o_rdata(mem_rdata)
    );

    // field decode
    logic [5:0]  op, fn;
    logic [4:0]  rs, rt, rd, sh;
    logic [31:0] imm, simm, a, b, pc4;
    assign op   = r_ins[31:26];
    assign fn   = r_ins[5:0];
    assign rs   = r_ins[25:21];
    assign rt   = r_ins[20:16];
    assign rd   = r_ins[15:11];
    assign sh   = r_ins[10:6];
    assign imm  = {16'd0, r_ins[15:0]};
    assign simm = {{16{r_ins[15]}}, r_ins[15:0]};
    assign a    = r_a;
    assign b    = r_b;
    assign pc4  = r_pc + 32'd4;

    // execute
    logic [31:0] x_val, x_npc;
    logic        x_wr, x_unk;
    logic [4:0]  x_dst;
    logic [2:0]  x_lb, x_sb;
    always_comb begin
        x_val = 32'd0; x_npc = pc4; x_wr = 1'b0; x_unk = 1'b0;
        x_dst = rt; x_lb = 3'd0; x_sb = 3'd0;
        unique case (op)
            OP_SPECIAL: begin
                x_wr = 1'b1; x_dst = rd;
                case (fn)
                    FN_ADD, FN_ADDU: x_val = a + b;
                    FN_SUB, FN_SUBU: x_val = a - b;
                    FN_AND:  x_val = a & b;
                    FN_OR:   x_val = a | b;
                    FN_NOR:  x_val = ~(a | b);
                    FN_SLT:  x_val = {31'd0, $signed(a) < $signed(b)};
                    FN_SLTU: x_val = {31'd0, a < b};
                    FN_SLL:  x_val = b << sh;
                    FN_SRL:  x_val = b >> sh;
                    FN_JR: begin x_wr = 1'b0; x_npc = a; end
                    default: begin x_wr = 1'b0; x_unk = 1'b1; end
                endcase
            end
            OP_ADDI, OP_ADDIU: begin x_wr = 1'b1; x_val = a + simm; end
            OP_ANDI: begin x_wr = 1'b1; x_val = a & imm; end
            OP_ORI:  begin x_wr = 1'b1; x_val = a | imm; end
            OP_SLTI: begin x_wr = 1'b1; x_val = {31'd0, $signed(a) < $signed(simm)}; end
            OP_SLTIU: begin x_wr = 1'b1; x_val = {31'd0, a < simm}; end
            OP_LUI:  begin x_wr = 1'b1; x_val = {r_ins[15:0], 16'd0}; end
            OP_BEQ:  if (a == b) x_npc = pc4 + {simm[29:0], 2'b00};
            OP_BNE:  if (a != b) x_npc = pc4 + {simm[29:0], 2'b00};
            OP_J:    x_npc = {pc4[31:28], r_ins[25:0], 2'b00};
            OP_JAL: begin
                x_npc = {pc4[31:28], r_ins[25:0], 2'b00};
                x_wr = 1'b1; x_dst = 5'd31; x_val = pc4;
            end
            OP_LBU: begin x_wr = 1'b1; x_lb = 3'd1; end
            OP_LHU: begin x_wr = 1'b1; x_lb = 3'd2; end
            OP_LW, OP_LL: begin x_wr = 1'b1; x_lb = 3'd4; end
            OP_SB: x_sb = 3'd1;
            OP_SH: x_sb = 3'd2;
            OP_SW: x_sb = 3'd4;
            OP_SC: begin x_sb = 3'd4; x_wr = 1'b1; x_val = 32'd1; end
            default: x_unk = 1'b1;
        endcase
    end

    logic [31:0] limit;
    assign limit = {19'd0, i_words, 2'b00};

    logic [31:0] fin_val;
    assign fin_val = (r_lb != 3'd0) ? r_ldv : r_val;

    assign o_sts.is_load  = (r_req.command == CMD_LOAD);
    assign o_sts.in_range = (r_pc < limit);
    assign o_sts.ld_bytes = x_lb;
    assign o_sts.st_bytes = x_sb;
    assign o_sts.clr_done = r_clr_done;
    assign o_rsp = r_rsp;

    // register file reset and write-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 32; i++) r_gpr[i] <= 32'd0;
        end else if (i_cmd.commit && r_wr && r_dst != 5'd0) begin
            r_gpr[r_dst] <= fin_val;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc       <= 32'd0;
            r_clr      <= '0;
            r_clr_done <= 1'b0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr      <= r_clr + 1'b1;
                r_clr_done <= (r_clr == AW'(MemBytes - 2));
            end
            if (i_cmd.commit) begin
                r_pc <= (r_npc >= limit) ? 32'd0 : r_npc;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_req) r_req <= i_req;
        if (i_cmd.cap_ins) r_ins <= {r_ins[23:0], mem_rdata};
        if (i_cmd.reg_rd) begin
            r_a <= r_gpr[rs];
            r_b <= r_gpr[rt];
        end
        if (i_cmd.exec) begin
            r_ea  <= a + simm;
            r_npc <= x_npc;
            r_val <= x_val;
            r_wr  <= x_wr;
            r_dst <= x_dst;
            r_lb  <= x_lb;
            r_sb  <= x_sb;
            r_status <= x_unk ? ST_UNKNOWN : ST_EXEC;
            r_ldv <= 32'd0;
        end
        if (i_cmd.cap_data) begin
            case (i_cmd.bidx)
                2'd0: r_ldv[7:0]   <= mem_rdata;
                2'd1: r_ldv[15:8]  <= mem_rdata;
                2'd2: r_ldv[23:16] <= mem_rdata;
                default: r_ldv[31:24] <= mem_rdata;
            endcase
        end
        if (i_cmd.fin_load || i_cmd.fin_range) begin
            r_rsp.status        <= i_cmd.fin_load ? ST_LOADED : ST_RANGE;
            r_rsp.next_pc       <= r_pc;
            r_rsp.reg_written   <= 1'b0;
            r_rsp.reg_index     <= 5'd0;
            r_rsp.reg_value     <= 32'd0;
            r_rsp.store_bytes   <= 3'd0;
            r_rsp.store_address <= 12'd0;
        end
        if (i_cmd.commit) begin
            r_rsp.status <= (r_npc >= limit) ? ST_WRAP : r_status;
            r_rsp.next_pc <= (r_npc >= limit) ? 32'd0 : r_npc;
            r_rsp.reg_written <= r_wr && r_dst != 5'd0;
            r_rsp.reg_index <= (r_wr && r_dst != 5'd0) ? r_dst : 5'd0;
            r_rsp.reg_value <= (r_wr && r_dst != 5'd0) ? fin_val : 32'd0;
            r_rsp.store_bytes <= r_sb;
            r_rsp.store_address <= (r_sb != 3'd0) ? 12'(r_ea[AW-1:0]) : 12'd0;
        end
    end
endmodule

// ===== rtl/core/mips_subset_instruction_step.sv =====
// Sequence: a load or range-fault request is answered with no fetch; a step does four
// byte-wide fetch reads on one memory port, register read, execute, per-byte loads/stores, commit.
// Throughput: one request at a time; a new request is taken once the result is delivered.
// Reset: synchronous active low; the byte memory is then zeroed by a sweep over all
// MemBytes addresses during which no request is taken (configuration still works).
// Registers and pc reset to zero at once.
module mips_subset_instruction_step #(
    parameter int MemBytes = mss_pkg::MemBytesDefault
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  mss_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_ready,
    output mss_pkg::t_rsp o_rsp,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import mss_pkg::*;

    logic [10:0] r_words;
    t_cmd cmd;
    t_sts sts;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_words <= 11'd0;
        end else if (psel && penable && pwrite && paddr[2] == REG_PROGRAM_WORDS
                     && paddr[1:0] == 2'd0) begin
            r_words <= pwdata[10:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_PROGRAM_WORDS) ? {21'd0, r_words} : 32'd0;

    mss_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .i_sts  (sts),
        .o_cmd  (cmd)
    );

    mss_dpath #(.MemBytes(MemBytes)) u_dpath (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (i_req),
        .i_words(r_words),
        .i_cmd  (cmd),
        .o_sts  (sts),
        .o_rsp  (o_rsp)
    );
endmodule

// ===== rtl/core/mss_checker.sv =====
// port-level checks for the stepper
module mss_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_ready,
    input logic          o_valid,
    input logic          i_ready,
    input mss_pkg::t_rsp o_rsp
);
    import mss_pkg::*;

    // one request in flight: never ready while a result waits
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("ready while result pending");

    // a result never appears in the cycle after a request is taken
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_valid) else $error("result too early");

    // status code in range
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_rsp.status <= ST_LOADED) else $error("bad status");

    // no register write or store reported on a load or range request
    a_nowrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_rsp.status == ST_LOADED || o_rsp.status == ST_RANGE))
        |-> !o_rsp.reg_written && o_rsp.store_bytes == 3'd0)
        else $error("side effect reported on non-step");
endmodule

bind mips_subset_instruction_step mss_checker u_chk (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .i_valid(i_valid),
    .o_ready(o_ready),
    .o_valid(o_valid),
    .i_ready(i_ready),
    .o_rsp  (o_rsp)
);
